// File: rtl/vibrato_modulated_delay_assert.svh
// assertion macros for the vibrato delay block
`ifndef VIBRATO_MODULATED_DELAY_ASSERT_SVH
`define VIBRATO_MODULATED_DELAY_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define VMD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define VMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/vmd_pkg.sv
// shared constants, codes and types of the vibrato delay block
package vmd_pkg;

	localparam int BUF_DEPTH       = 4096;
	localparam int ADDR_BITS       = $clog2(BUF_DEPTH);
	localparam int POS_BITS        = ADDR_BITS + 16;
	localparam int SAMPLE_BITS     = 16;
	localparam int SINE_TABLE_BITS = 10;
	localparam int SWEEP_BITS      = 28;

	localparam logic [17:0] SIN_C1 = 18'd102944;
	localparam logic [17:0] SIN_C3 = 18'd42334;
	localparam logic [17:0] SIN_C5 = 18'd5223;
	localparam logic [17:0] SIN_C7 = 18'd307;
	localparam logic [17:0] SIN_C9 = 18'd11;

	localparam logic [1:0] MODE_LINEAR   = 2'd0;
	localparam logic [1:0] MODE_CUBIC    = 2'd1;
	localparam logic [1:0] MODE_NEAREST  = 2'd2;
	// spare code, behaves as nearest
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	localparam logic [7:0] REG_SWEEP_DELAY = 8'd0;
	localparam logic [7:0] REG_PHASE_STEP  = 8'd1;
	localparam logic [7:0] REG_INTERP_MODE = 8'd2;
	localparam logic [7:0] REG_STEREO_ON   = 8'd3;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_X2, ST_C9, ST_C7, ST_C5, ST_C3, ST_C1, ST_LFO,
		ST_POS, ST_READ, ST_CAPT, ST_LIN, ST_CA, ST_CB, ST_CC, ST_FIN, ST_DONE
	} state_t;

endpackage

// File: rtl/vibrato_modulated_delay.sv
// top level of the lfo modulated stereo vibrato delay line
//
// channel   dir  handshake             payload
// s_*       in   s_tvalid/s_tready     s_tdata  {right_sample, left_sample}
// m_*       out  m_tvalid/m_tready     m_tdata  {right_out, left_out}
// cfg_*     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one sample pair at a time, paced by the single shared 30x18 multiplier and
// the one read port of each delay ram (four reads for cubic)
// after reset a clearing pass zeroes all BUF_DEPTH (4096) entries of both rams,
// s_tready stays low meanwhile; config writes are taken always
// a result waits in the output register; the next pair is accepted meanwhile,
// and only the final write-back stalls while m_tready is low
`include "vibrato_modulated_delay_assert.svh"

module vibrato_modulated_delay (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] left_sample, [31:16] right_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] left_out, [31:16] right_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int AB  = vmd_pkg::ADDR_BITS;
	localparam int SB  = vmd_pkg::SAMPLE_BITS;
	localparam int STB = vmd_pkg::SINE_TABLE_BITS;
	localparam int PB  = vmd_pkg::POS_BITS;

	vmd_pkg::state_t state_q, state_d;

	// configuration
	logic [vmd_pkg::SWEEP_BITS-1:0] sweep_q;
	logic [31:0]                    step_q;
	logic [1:0]                     mode_q;
	logic                           stereo_q;

	// architectural state
	logic [AB-1:0] wi_q;
	logic [31:0]   phase_q;
	logic [AB-1:0] clr_cnt_q;

	// per item working registers
	logic signed [SB-1:0] in_l_q, in_r_q;
	logic [16:0]          x_q, x2_q;
	logic [1:0]           quad_q;
	logic signed [47:0]   prod_q;
	logic [PB-1:0]        pos_q;
	logic [1:0]           rd_cnt_q;
	logic                 rd_vld_s1;
	logic [1:0]           rd_tap_s1;
	logic signed [SB-1:0] tap_l_q [4];
	logic signed [SB-1:0] tap_r_q [4];
	logic                 chan_q;
	logic signed [SB-1:0] res_l_q, res_r_q;
	logic signed [SB-1:0] out_l_q, out_r_q;
	logic                 m_tvalid_q;

	// ram ports
	logic          ram_we, ram_we_r;
	logic [AB-1:0] ram_waddr, ram_raddr;
	logic [SB-1:0] ram_wdata_l, ram_wdata_r, ram_rdata_l, ram_rdata_r;

	// datapath
	logic signed [29:0] ma;
	logic signed [17:0] mb;
	logic signed [47:0] mul;
	logic [17:0]        lfo_k, t_lfo;
	logic [17:0]        s_raw;
	logic [16:0]        s_clamp, lfo;
	logic [STB-1:0]     ph_idx;
	logic [16:0]        x_new;
	logic               is_cubic, is_linear, can_done;
	logic [1:0]         last_rd;
	logic [AB-1:0]      pos_i;
	logic [15:0]        pos_f;
	logic signed [SB-1:0]  s0, s1, s2, s3;
	logic signed [23:0]    c0, c1, c2, c3, prod_t, t_next, t_fin;
	logic signed [31:0]    prod_hi, fin_wide;
	logic signed [47:0]    lin_v;
	logic signed [SB-1:0]  fin_res;
	logic signed [SB:0]    lin_diff;

	function automatic logic signed [SB-1:0] sat(input logic signed [31:0] v);
		logic signed [31:0] hi, lo;
		hi = 32'sd1 <<< (SB - 1);
		hi = hi - 32'sd1;
		lo = -hi - 32'sd1;
		if (v > hi) return hi[SB-1:0];
		if (v < lo) return lo[SB-1:0];
		return v[SB-1:0];
	endfunction

	assign is_cubic  = (mode_q == vmd_pkg::MODE_CUBIC);
	assign is_linear = (mode_q == vmd_pkg::MODE_LINEAR);
	// unused mode code falls to nearest
	assign last_rd   = is_cubic ? 2'd3 : (is_linear ? 2'd1 : 2'd0);
	assign can_done  = !m_tvalid_q || m_tready;

	// quarter-wave position from the top phase bits
	assign ph_idx = phase_q[31 -: STB];
	always_comb begin
		x_new = {1'b0, ph_idx[STB-3:0], {(18 - STB){1'b0}}};
		if (ph_idx[STB-2]) begin
			x_new = 17'd65536 - x_new;
		end
	end

	// polynomial coefficient for this horner step
	always_comb begin
		case (state_q)
			vmd_pkg::ST_C7: lfo_k = vmd_pkg::SIN_C7;
			vmd_pkg::ST_C5: lfo_k = vmd_pkg::SIN_C5;
			vmd_pkg::ST_C3: lfo_k = vmd_pkg::SIN_C3;
			vmd_pkg::ST_C1: lfo_k = vmd_pkg::SIN_C1;
			default:        lfo_k = '0;
		endcase
	end
	assign t_lfo = lfo_k - prod_q[33:16];

	// sine magnitude, clamp and offset to 0..65536
	assign s_raw   = prod_q[33:16];
	assign s_clamp = (s_raw > 18'd65536) ? 17'd65536 : s_raw[16:0];
	always_comb begin
		logic [17:0] sum;
		if (quad_q[1]) begin
			sum = 18'd65536 - {1'b0, s_clamp};
		end else begin
			sum = 18'd65536 + {1'b0, s_clamp};
		end
		lfo = sum[17:1];
	end

	// read position split
	assign pos_i = pos_q[PB-1:16];
	assign pos_f = pos_q[15:0];

	// taps of the channel in work
	assign s0 = chan_q ? tap_r_q[0] : tap_l_q[0];
	assign s1 = chan_q ? tap_r_q[1] : tap_l_q[1];
	assign s2 = chan_q ? tap_r_q[2] : tap_l_q[2];
	assign s3 = chan_q ? tap_r_q[3] : tap_l_q[3];

	// doubled catmull-rom coefficients
	assign c0 = -24'(s0) + 24'(3 * 24'(s1)) - 24'(3 * 24'(s2)) + 24'(s3);
	assign c1 = 24'(2 * 24'(s0)) - 24'(5 * 24'(s1)) + 24'(4 * 24'(s2)) - 24'(s3);
	assign c2 = 24'(s2) - 24'(s0);
	assign c3 = 24'(2 * 24'(s1));

	assign prod_hi  = prod_q[47:16];
	assign prod_t   = prod_hi[23:0];
	assign t_next   = prod_t + ((state_q == vmd_pkg::ST_CB) ? c1 : c2);
	assign t_fin    = prod_t + c3;
	assign lin_diff = (SB + 1)'(s1) - (SB + 1)'(s0);

	// linear as s0 + (s1 - s0) * f, rounded
	assign lin_v = (48'(s0) <<< 16) + prod_q + 48'sd32768;

	always_comb begin
		logic signed [23:0] tr;
		tr = (t_fin + 24'sd1) >>> 1;
		if (is_cubic) begin
			fin_wide = 32'(tr);
		end else if (is_linear) begin
			fin_wide = lin_v[47:16];
		end else begin
			fin_wide = 32'(s0);
		end
		fin_res = sat(fin_wide);
	end

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			vmd_pkg::ST_X2: begin
				ma = 30'(x_q);
				mb = 18'(x_q);
			end
			vmd_pkg::ST_C9: begin
				ma = 30'(prod_q[32:16]);
				mb = vmd_pkg::SIN_C9;
			end
			vmd_pkg::ST_C7, vmd_pkg::ST_C5, vmd_pkg::ST_C3: begin
				ma = 30'(x2_q);
				mb = t_lfo;
			end
			vmd_pkg::ST_C1: begin
				ma = 30'(x_q);
				mb = t_lfo;
			end
			vmd_pkg::ST_LFO: begin
				ma = 30'(sweep_q);
				mb = 18'(lfo);
			end
			vmd_pkg::ST_LIN: begin
				ma = 30'(lin_diff);
				mb = 18'(pos_f);
			end
			vmd_pkg::ST_CA: begin
				ma = 30'(c0);
				mb = 18'(pos_f);
			end
			vmd_pkg::ST_CB, vmd_pkg::ST_CC: begin
				ma = 30'(t_next);
				mb = 18'(pos_f);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end
	assign mul = ma * mb;

	// read address per tap
	always_comb begin
		if (is_cubic) begin
			ram_raddr = pos_i - AB'(1) + AB'(rd_cnt_q);
		end else if (is_linear) begin
			ram_raddr = pos_i + AB'(rd_cnt_q);
		end else begin
			ram_raddr = pos_i + AB'(pos_f[15]);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vmd_pkg::ST_CLEAR: if (clr_cnt_q == AB'(vmd_pkg::BUF_DEPTH - 1)) begin
				state_d = vmd_pkg::ST_IDLE;
			end
			vmd_pkg::ST_IDLE: if (s_tvalid) begin
				state_d = vmd_pkg::ST_X2;
			end
			vmd_pkg::ST_X2:  state_d = vmd_pkg::ST_C9;
			vmd_pkg::ST_C9:  state_d = vmd_pkg::ST_C7;
			vmd_pkg::ST_C7:  state_d = vmd_pkg::ST_C5;
			vmd_pkg::ST_C5:  state_d = vmd_pkg::ST_C3;
			vmd_pkg::ST_C3:  state_d = vmd_pkg::ST_C1;
			vmd_pkg::ST_C1:  state_d = vmd_pkg::ST_LFO;
			vmd_pkg::ST_LFO: state_d = vmd_pkg::ST_POS;
			vmd_pkg::ST_POS: state_d = vmd_pkg::ST_READ;
			vmd_pkg::ST_READ: if (rd_cnt_q == last_rd) begin
				state_d = vmd_pkg::ST_CAPT;
			end
			vmd_pkg::ST_CAPT: begin
				if (is_cubic) state_d = vmd_pkg::ST_CA;
				else if (is_linear) state_d = vmd_pkg::ST_LIN;
				else state_d = vmd_pkg::ST_FIN;
			end
			vmd_pkg::ST_LIN: state_d = vmd_pkg::ST_FIN;
			vmd_pkg::ST_CA:  state_d = vmd_pkg::ST_CB;
			vmd_pkg::ST_CB:  state_d = vmd_pkg::ST_CC;
			vmd_pkg::ST_CC:  state_d = vmd_pkg::ST_FIN;
			vmd_pkg::ST_FIN: begin
				if (!chan_q && stereo_q) begin
					// same taps path again for the right channel
					state_d = vmd_pkg::ST_CAPT;
				end else begin
					state_d = vmd_pkg::ST_DONE;
				end
			end
			vmd_pkg::ST_DONE: if (can_done) begin
				state_d = vmd_pkg::ST_IDLE;
			end
			default: state_d = vmd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vmd_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q    <= '0;
			step_q     <= '0;
			mode_q     <= vmd_pkg::MODE_LINEAR;
			stereo_q   <= 1'b1;
			wi_q       <= '0;
			phase_q    <= '0;
			clr_cnt_q  <= '0;
			rd_cnt_q   <= '0;
			rd_vld_s1  <= 1'b0;
			chan_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					vmd_pkg::REG_SWEEP_DELAY: sweep_q  <= cfg_data[vmd_pkg::SWEEP_BITS-1:0];
					vmd_pkg::REG_PHASE_STEP:  step_q   <= cfg_data;
					vmd_pkg::REG_INTERP_MODE: mode_q   <= cfg_data[1:0];
					vmd_pkg::REG_STEREO_ON:   stereo_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == vmd_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AB'(1);
			end
			rd_vld_s1 <= (state_q == vmd_pkg::ST_READ);
			if (state_q == vmd_pkg::ST_READ) begin
				rd_cnt_q <= rd_cnt_q + 2'd1;
			end else begin
				rd_cnt_q <= '0;
			end
			if (state_q == vmd_pkg::ST_IDLE) begin
				chan_q <= 1'b0;
			end else if (state_q == vmd_pkg::ST_FIN) begin
				chan_q <= 1'b1;
			end
			if (state_q == vmd_pkg::ST_DONE && can_done) begin
				m_tvalid_q <= 1'b1;
				wi_q       <= wi_q + AB'(1);
				phase_q    <= phase_q + step_q;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		prod_q    <= mul;
		rd_tap_s1 <= rd_cnt_q;
		if (state_q == vmd_pkg::ST_IDLE) begin
			in_l_q <= s_tdata[SB-1:0];
			in_r_q <= s_tdata[2*SB-1:SB];
			x_q    <= x_new;
			quad_q <= ph_idx[STB-1 -: 2];
		end
		if (state_q == vmd_pkg::ST_C9) begin
			x2_q <= prod_q[32:16];
		end
		if (state_q == vmd_pkg::ST_POS) begin
			pos_q <= {wi_q - AB'(3), 16'd0} - PB'(prod_q[43:16]);
		end
		if (rd_vld_s1) begin
			tap_l_q[rd_tap_s1] <= ram_rdata_l;
			tap_r_q[rd_tap_s1] <= ram_rdata_r;
		end
		if (state_q == vmd_pkg::ST_FIN) begin
			if (chan_q) begin
				res_r_q <= fin_res;
			end else begin
				res_l_q <= fin_res;
				res_r_q <= '0;
			end
		end
		if (state_q == vmd_pkg::ST_DONE && can_done) begin
			out_l_q <= res_l_q;
			out_r_q <= res_r_q;
		end
	end

	// write port: clearing pass, or the new pair at the write index
	assign ram_we      = (state_q == vmd_pkg::ST_CLEAR) ||
	                     (state_q == vmd_pkg::ST_DONE && can_done);
	assign ram_we_r    = (state_q == vmd_pkg::ST_CLEAR) ||
	                     (state_q == vmd_pkg::ST_DONE && can_done && stereo_q);
	assign ram_waddr   = (state_q == vmd_pkg::ST_CLEAR) ? clr_cnt_q : wi_q;
	assign ram_wdata_l = (state_q == vmd_pkg::ST_CLEAR) ? '0 : in_l_q;
	assign ram_wdata_r = (state_q == vmd_pkg::ST_CLEAR) ? '0 : in_r_q;

	vmd_ram #(.WIDTH(SB), .DEPTH(vmd_pkg::BUF_DEPTH)) u_left_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata_l),
		.raddr (ram_raddr),
		.rdata (ram_rdata_l)
	);

	vmd_ram #(.WIDTH(SB), .DEPTH(vmd_pkg::BUF_DEPTH)) u_right_ram (
		.clk   (clk),
		.we    (ram_we_r),
		.waddr (ram_waddr),
		.wdata (ram_wdata_r),
		.raddr (ram_raddr),
		.rdata (ram_rdata_r)
	);

	// ports
	assign s_tready  = (state_q == vmd_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {out_r_q, out_l_q};

	// checks
	`VMD_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "second beat taken while busy")
	`VMD_ASSERT_NOW(a_no_write_stall, clk, arst_n, state_q == vmd_pkg::ST_DONE && m_tvalid_q && !m_tready, !ram_we, "write-back while result held")
	`VMD_ASSERT_NOW(a_read_window, clk, arst_n, rd_vld_s1, state_q == vmd_pkg::ST_READ || state_q == vmd_pkg::ST_CAPT, "read data outside capture window")
	`VMD_ASSERT_NOW(a_clear_quiet, clk, arst_n, state_q == vmd_pkg::ST_CLEAR, !m_tvalid_q && !s_tready, "traffic during clearing pass")

endmodule

// File: rtl/vmd_ram.sv
// generic simple dual port ram with registered read
module vmd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
